@@ rtl/msc_pkg.sv @@
// Shared types, opcode constants and defaults for the MIPS subset core.
package msc_pkg;

  localparam int unsigned XLEN              = 32;
  localparam int unsigned REG_ADDR_W        = 5;
  localparam int unsigned REG_COUNT         = 32;
  localparam int unsigned DATA_WORDS_DEFAULT = 32;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_EXEC     = 2'd0,
    OP_LOAD_REG = 2'd1,
    OP_LOAD_MEM = 2'd2
  } op_e;

  // Kind of write reported with each result word.
  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_REG  = 2'd1,
    WK_MEM  = 2'd2
  } wkind_e;

  // Primary opcodes.
  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_J     = 6'b000010;
  localparam logic [5:0] OPC_BEQ   = 6'b000100;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SW    = 6'b101011;

  // R-type function codes.
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_NOR = 6'b100111;
  localparam logic [5:0] FN_SLT = 6'b101010;

  // Register file write port.
  typedef struct packed {
    logic                  en;
    logic [REG_ADDR_W-1:0] idx;
    logic [XLEN-1:0]       data;
  } rf_wr_t;

endpackage

@@ rtl/msc_if.sv @@
// Valid/ready channel interfaces for the input and result words of the core.
interface msc_in_if;
  import msc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [XLEN-1:0]              instr;
  logic [REG_ADDR_W-1:0]        preload_index;
  logic signed [XLEN-1:0]       preload_value;

  modport source (output valid, output op, output instr, output preload_index,
                  output preload_value, input ready);
  modport sink   (input valid, input op, input instr, input preload_index,
                  input preload_value, output ready);
endinterface

interface msc_out_if;
  import msc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [XLEN-1:0]              next_pc;
  logic [1:0]                   write_kind;
  logic [REG_ADDR_W-1:0]        write_index;
  logic signed [XLEN-1:0]       write_value;
  logic [XLEN-1:0]              executed_count;

  modport source (output valid, output next_pc, output write_kind, output write_index,
                  output write_value, output executed_count, input ready);
  modport sink   (input valid, input next_pc, input write_kind, input write_index,
                  input write_value, input executed_count, output ready);
endinterface

@@ rtl/msc_regfile.sv @@
// Register file with registered two-port read, write bypass and per-entry valid bits.
module msc_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [msc_pkg::REG_ADDR_W-1:0] rd_addr_a_i,
  input  logic [msc_pkg::REG_ADDR_W-1:0] rd_addr_b_i,
  input  msc_pkg::rf_wr_t                wr_i,
  output logic [msc_pkg::XLEN-1:0]       rd_data_a_o,
  output logic [msc_pkg::XLEN-1:0]       rd_data_b_o
);
  import msc_pkg::*;

  logic [XLEN-1:0]      mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [XLEN-1:0]      rd_data_a_q, rd_data_b_q;
  logic [XLEN-1:0]      rd_a_d, rd_b_d;

  // An entry never written reads as zero; a write in the same cycle is passed through.
  always_comb begin
    rd_a_d = vld_q[rd_addr_a_i] ? mem_q[rd_addr_a_i] : '0;
    rd_b_d = vld_q[rd_addr_b_i] ? mem_q[rd_addr_b_i] : '0;
    if (wr_i.en && (wr_i.idx == rd_addr_a_i)) begin
      rd_a_d = wr_i.data;
    end
    if (wr_i.en && (wr_i.idx == rd_addr_b_i)) begin
      rd_b_d = wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_a_q <= rd_a_d;
      rd_data_b_q <= rd_b_d;
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

@@ rtl/msc_word_slot.sv @@
// Reduces a word address modulo the data memory depth with residue tables.
module msc_word_slot #(
  parameter int unsigned DATA_WORDS = msc_pkg::DATA_WORDS_DEFAULT
) (
  input  logic [msc_pkg::XLEN-3:0]       word_i,
  output logic [$clog2(DATA_WORDS)-1:0]  slot_o
);
  import msc_pkg::*;

  localparam int unsigned AW  = $clog2(DATA_WORDS);
  localparam int unsigned SW  = AW + 2;
  localparam int unsigned P8  = 256 % DATA_WORDS;
  localparam int unsigned P16 = 65536 % DATA_WORDS;
  localparam int unsigned P24 = 16777216 % DATA_WORDS;
  localparam logic [SW-1:0] D1 = SW'(DATA_WORDS);
  localparam logic [SW-1:0] D2 = SW'(2 * DATA_WORDS);
  localparam logic [SW-1:0] D3 = SW'(3 * DATA_WORDS);

  logic [AW-1:0] t0 [256];
  logic [AW-1:0] t1 [256];
  logic [AW-1:0] t2 [256];
  logic [AW-1:0] t3 [64];
  logic [SW-1:0] sum;

  // Residue of each byte of the address, weighted by its position.
  for (genvar c = 0; c < 256; c++) begin : g_tab
    localparam int unsigned R0 = c % DATA_WORDS;
    localparam int unsigned R1 = (c * P8) % DATA_WORDS;
    localparam int unsigned R2 = (c * P16) % DATA_WORDS;
    assign t0[c] = AW'(R0);
    assign t1[c] = AW'(R1);
    assign t2[c] = AW'(R2);
  end

  for (genvar c = 0; c < 64; c++) begin : g_tab_top
    localparam int unsigned R3 = (c * P24) % DATA_WORDS;
    assign t3[c] = AW'(R3);
  end

  assign sum = SW'(t0[word_i[7:0]]) + SW'(t1[word_i[15:8]])
             + SW'(t2[word_i[23:16]]) + SW'(t3[word_i[29:24]]);

  // The sum stays below four times the depth, so one parallel compare settles it.
  always_comb begin
    if (sum >= D3) begin
      slot_o = AW'(sum - D3);
    end else if (sum >= D2) begin
      slot_o = AW'(sum - D2);
    end else if (sum >= D1) begin
      slot_o = AW'(sum - D1);
    end else begin
      slot_o = AW'(sum);
    end
  end

endmodule

@@ rtl/mips_subset_single_cycle_core_top.sv @@
// Top level of the MIPS subset core: operand read, execute stage and result register.
// Throughput: one word per cycle for any instruction mix while the result channel is
// ready and no clearing pass runs. An accepted word is held in the execute stage
// registers, then in the result register; the operand read, the execute stage and
// the result register are the three steps. Reset clears pc, instruction count and
// register file at once; a clearing pass then zeroes data memory, input held off.
module mips_subset_single_cycle_core_top #(
  parameter int unsigned DATA_WORDS = msc_pkg::DATA_WORDS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msc_in_if.sink      in_i,
  msc_out_if.source   out_o
);
  import msc_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  // Pipeline control. The whole pipe advances when the result register is free
  // or is being emptied; the input is held off during the memory clearing pass.
  logic adv, in_fire, s1_fire;
  logic s1_valid_q, out_valid_q;

  // Architectural state kept in flops.
  logic [XLEN-1:0] pc_q, cnt_q;

  // Data memory clearing pass after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  // Execute stage inputs.
  logic [1:0]            s1_op_q;
  logic [XLEN-1:0]       s1_instr_q;
  logic [REG_ADDR_W-1:0] s1_pidx_q;
  logic [XLEN-1:0]       s1_pval_q;

  // Result register.
  logic [XLEN-1:0]       out_pc_q, out_val_q, out_cnt_q;
  wkind_e                out_kind_q;
  logic [REG_ADDR_W-1:0] out_idx_q;
  logic                  out_is_lw_q;
  logic [XLEN-1:0]       s2_wval;

  // Register file and data memory.
  rf_wr_t          rf_wr;
  logic [XLEN-1:0] ra_q, rb_q;
  logic [XLEN-1:0] dmem_q [DATA_WORDS];
  logic [XLEN-1:0] dmem_rdata_q;

  // Decode and execute.
  logic [5:0]            opc, fn;
  logic [REG_ADDR_W-1:0] rs, rt, rd;
  logic [XLEN-1:0]       op_a, op_b, imm_sext, seq_pc, addr;
  logic [XLEN-3:0]       slot_word;
  logic [AW-1:0]         slot;
  logic                  fwd_en, alu_ok;
  logic [XLEN-1:0]       alu_res;

  wkind_e                kind_d;
  logic [REG_ADDR_W-1:0] idx_d;
  logic [XLEN-1:0]       val_d, npc_d, cnt_d, mem_wdata;
  logic                  is_lw_d, mem_we_d, mem_re_d;

  assign adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = adv && !clr_busy_q;
  assign in_fire = in_i.valid && in_i.ready;
  assign s1_fire = adv && s1_valid_q;

  // The word in the result register writes its register every cycle it is held.
  // Rewriting the same value is harmless, and the read bypass sees the write.
  assign s2_wval    = out_is_lw_q ? dmem_rdata_q : out_val_q;
  assign rf_wr.en   = out_valid_q && (out_kind_q == WK_REG);
  assign rf_wr.idx  = out_idx_q;
  assign rf_wr.data = s2_wval;

  msc_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (in_i.instr[25:21]),
    .rd_addr_b_i (in_i.instr[20:16]),
    .wr_i        (rf_wr),
    .rd_data_a_o (ra_q),
    .rd_data_b_o (rb_q)
  );

  // Field extraction.
  assign opc = s1_instr_q[31:26];
  assign rs  = s1_instr_q[25:21];
  assign rt  = s1_instr_q[20:16];
  assign rd  = s1_instr_q[15:11];
  assign fn  = s1_instr_q[5:0];

  // Operands were read while the previous word was still executing, so a
  // register write held in the result register is forwarded here. Register zero
  // is never written, hence never forwarded.
  assign fwd_en = out_valid_q && (out_kind_q == WK_REG);
  assign op_a   = (fwd_en && (out_idx_q == rs)) ? s2_wval : ra_q;
  assign op_b   = (fwd_en && (out_idx_q == rt)) ? s2_wval : rb_q;

  assign imm_sext = {{16{s1_instr_q[15]}}, s1_instr_q[15:0]};
  assign seq_pc   = pc_q + 32'd4;
  assign addr     = op_a + imm_sext;

  // A data preload indexes the memory by its own field rather than by an address.
  assign slot_word = (s1_op_q == OP_LOAD_MEM) ? (XLEN-2)'(s1_pidx_q) : addr[XLEN-1:2];

  msc_word_slot #(
    .DATA_WORDS (DATA_WORDS)
  ) u_word_slot (
    .word_i (slot_word),
    .slot_o (slot)
  );

  always_comb begin
    kind_d    = WK_NONE;
    idx_d     = '0;
    val_d     = '0;
    is_lw_d   = 1'b0;
    mem_we_d  = 1'b0;
    mem_re_d  = 1'b0;
    mem_wdata = op_b;
    npc_d     = pc_q;
    cnt_d     = cnt_q;
    alu_ok    = 1'b0;
    alu_res   = '0;
    case (s1_op_q)
      OP_EXEC: begin
        npc_d = seq_pc;
        cnt_d = cnt_q + 32'd1;
        case (opc)
          OPC_RTYPE: begin
            alu_ok = 1'b1;
            case (fn)
              FN_ADD:  alu_res = op_a + op_b;
              FN_SUB:  alu_res = op_a - op_b;
              FN_AND:  alu_res = op_a & op_b;
              FN_OR:   alu_res = op_a | op_b;
              FN_NOR:  alu_res = ~(op_a | op_b);
              FN_SLT:  alu_res = XLEN'($signed(op_a) < $signed(op_b));
              default: alu_ok  = 1'b0;
            endcase
            if (alu_ok && (rd != '0)) begin
              kind_d = WK_REG;
              idx_d  = rd;
              val_d  = alu_res;
            end
          end
          OPC_LW: begin
            mem_re_d = 1'b1;
            if (rt != '0) begin
              kind_d  = WK_REG;
              idx_d   = rt;
              is_lw_d = 1'b1;
            end
          end
          OPC_SW: begin
            mem_we_d = 1'b1;
            kind_d   = WK_MEM;
            idx_d    = REG_ADDR_W'(slot);
            val_d    = op_b;
          end
          OPC_BEQ: begin
            if (op_a == op_b) begin
              npc_d = seq_pc + {imm_sext[XLEN-3:0], 2'b00};
            end
          end
          OPC_J: begin
            npc_d = {seq_pc[31:28], s1_instr_q[25:0], 2'b00};
          end
          default: begin
            // Unknown opcodes only move the pc on and count as executed.
            npc_d = seq_pc;
          end
        endcase
      end
      OP_LOAD_REG: begin
        if (s1_pidx_q != '0) begin
          kind_d = WK_REG;
          idx_d  = s1_pidx_q;
          val_d  = s1_pval_q;
        end
      end
      OP_LOAD_MEM: begin
        mem_we_d  = 1'b1;
        mem_wdata = s1_pval_q;
        kind_d    = WK_MEM;
        idx_d     = REG_ADDR_W'(slot);
        val_d     = s1_pval_q;
      end
      default: begin
        // The unused operation code leaves everything as it is.
        npc_d = pc_q;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      cnt_q       <= '0;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      if (adv) begin
        s1_valid_q  <= in_fire;
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        pc_q  <= npc_d;
        cnt_q <= cnt_d;
      end
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= in_i.op;
      s1_instr_q <= in_i.instr;
      s1_pidx_q  <= in_i.preload_index;
      s1_pval_q  <= in_i.preload_value;
    end
    if (s1_fire) begin
      out_pc_q    <= npc_d;
      out_kind_q  <= kind_d;
      out_idx_q   <= idx_d;
      out_val_q   <= val_d;
      out_is_lw_q <= is_lw_d;
      out_cnt_q   <= cnt_d;
    end
  end

  // Data memory: one write port shared by the clearing pass and the execute
  // stage, and one registered read port used by loads.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dmem_q[clr_idx_q] <= '0;
    end else if (s1_fire && mem_we_d) begin
      dmem_q[slot] <= mem_wdata;
    end
    if (s1_fire && mem_re_d) begin
      dmem_rdata_q <= dmem_q[slot];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_pc        = out_pc_q;
  assign out_o.write_kind     = out_kind_q;
  assign out_o.write_index    = out_idx_q;
  assign out_o.write_value    = s2_wval;
  assign out_o.executed_count = out_cnt_q;

endmodule

@@ rtl/msc_checker.sv @@
// Port-level assertions for the MIPS subset core, bound to the top level.
module msc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [msc_pkg::XLEN-1:0]       out_next_pc_i,
  input logic [1:0]                     out_write_kind_i,
  input logic [msc_pkg::REG_ADDR_W-1:0] out_write_index_i,
  input logic [msc_pkg::XLEN-1:0]       out_write_value_i,
  input logic [msc_pkg::XLEN-1:0]       out_executed_count_i
);
  import msc_pkg::*;

  logic            out_fire;
  logic            seen_q;
  logic [XLEN-1:0] last_cnt_q;

  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_fire) begin
      seen_q     <= 1'b1;
      last_cnt_q <= out_executed_count_i;
    end
  end

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_next_pc_i)
      && $stable(out_write_kind_i) && $stable(out_write_index_i)
      && $stable(out_write_value_i) && $stable(out_executed_count_i))
    else $error("result word changed while stalled");

  // Each word executes at most one instruction.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q |-> (out_executed_count_i == last_cnt_q)
      || (out_executed_count_i == last_cnt_q + 32'd1))
    else $error("instruction count jumped between result words");

  // A word without a write reports zero index and value.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_write_kind_i == WK_NONE)
      |-> (out_write_index_i == '0) && (out_write_value_i == '0))
    else $error("empty write carries index or value");

  // Register zero is never reported as written.
  a_no_reg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_write_kind_i == WK_REG) |-> (out_write_index_i != '0))
    else $error("write to register zero reported");

endmodule

bind mips_subset_single_cycle_core_top msc_checker u_msc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_next_pc_i        (out_o.next_pc),
  .out_write_kind_i     (out_o.write_kind),
  .out_write_index_i    (out_o.write_index),
  .out_write_value_i    (out_o.write_value),
  .out_executed_count_i (out_o.executed_count)
);

@@ verif/mips_subset_single_cycle_core_top_test.sv @@
// Self-checking testbench for the MIPS subset core: predicts every result word and compares it.
module mips_subset_single_cycle_core_top_test;
  import msc_pkg::*;

  localparam int unsigned DATA_WORDS  = DATA_WORDS_DEFAULT;
  // The op field is two bits wide, but only three codes are defined. The fourth must be ignored.
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;

  // The record that retiring one input word leaves behind, as the result channel shows it.
  typedef struct {
    logic [31:0] next_pc;
    wkind_e      kind;
    logic [4:0]  index;
    logic [31:0] value;
    logic [31:0] count;
  } retire_t;

  logic clk_i;
  logic rst_ni;

  msc_in_if  in_bus ();
  msc_out_if out_bus ();

  mips_subset_single_cycle_core_top #(
    .DATA_WORDS(DATA_WORDS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // The testbench's own copy of the architectural state. It is updated in acceptance order.
  logic [31:0] arch_pc;
  logic [31:0] arch_count;
  logic [31:0] arch_regs [32];
  logic [31:0] arch_mem  [DATA_WORDS];

  retire_t     retire_q [$];
  int unsigned mismatch_count;
  // When set, neither the sender nor the receiver inserts idle cycles.
  bit          quiet;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Applies one accepted word to the architectural state and returns what it retires.
  function automatic retire_t retire_word(logic [1:0] op, logic [31:0] instr,
                                          logic [4:0] pidx, logic [31:0] pval);
    retire_t     r;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] seq;
    logic [31:0] alu;
    logic [31:0] slot;
    bit          alu_ok;
    r.kind  = WK_NONE;
    r.index = '0;
    r.value = '0;
    if (op == OP_EXEC) begin
      opc = instr[31:26];
      rs  = instr[25:21];
      rt  = instr[20:16];
      rd  = instr[15:11];
      fn  = instr[5:0];
      a   = arch_regs[rs];
      b   = arch_regs[rt];
      imm = {{16{instr[15]}}, instr[15:0]};
      seq = arch_pc + 32'd4;
      // Loads and stores drop the two low address bits and wrap round the data memory.
      slot    = ((a + imm) >> 2) % DATA_WORDS;
      arch_pc = seq;
      case (opc)
        OPC_RTYPE: begin
          alu_ok = 1'b1;
          case (fn)
            FN_ADD:  alu = a + b;
            FN_SUB:  alu = a - b;
            FN_AND:  alu = a & b;
            FN_OR:   alu = a | b;
            FN_NOR:  alu = ~(a | b);
            FN_SLT:  alu = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            default: begin
              alu    = '0;
              alu_ok = 1'b0;
            end
          endcase
          if (alu_ok && rd != 5'd0) begin
            arch_regs[rd] = alu;
            r.kind        = WK_REG;
            r.index       = rd;
            r.value       = alu;
          end
        end
        OPC_LW: begin
          if (rt != 5'd0) begin
            arch_regs[rt] = arch_mem[slot];
            r.kind        = WK_REG;
            r.index       = rt;
            r.value       = arch_mem[slot];
          end
        end
        OPC_SW: begin
          arch_mem[slot] = b;
          r.kind         = WK_MEM;
          r.index        = slot[4:0];
          r.value        = b;
        end
        OPC_BEQ: begin
          if (a == b) arch_pc = seq + (imm << 2);
        end
        OPC_J: begin
          arch_pc = {seq[31:28], instr[25:0], 2'b00};
        end
        default: begin
        end
      endcase
      arch_count = arch_count + 32'd1;
    end else if (op == OP_LOAD_REG) begin
      if (pidx != 5'd0) begin
        arch_regs[pidx] = pval;
        r.kind          = WK_REG;
        r.index         = pidx;
        r.value         = pval;
      end
    end else if (op == OP_LOAD_MEM) begin
      slot           = pidx % DATA_WORDS;
      arch_mem[slot] = pval;
      r.kind         = WK_MEM;
      r.index        = slot[4:0];
      r.value        = pval;
    end
    r.next_pc = arch_pc;
    r.count   = arch_count;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn, logic [4:0] shamt = 5'd0);
    return {OPC_RTYPE, rs, rt, rd, shamt, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // Mostly well-formed instructions with random operands. Some R-type words carry a
  // random function code, and a small share are raw words, so that unsupported encodings
  // turn up too.
  function automatic logic [31:0] random_instr();
    int unsigned pick;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    pick = $urandom_range(99);
    rs   = 5'($urandom_range(31));
    rt   = 5'($urandom_range(31));
    if (pick < 55) begin
      case ($urandom_range(6))
        0:       fn = FN_ADD;
        1:       fn = FN_SUB;
        2:       fn = FN_AND;
        3:       fn = FN_OR;
        4:       fn = FN_NOR;
        5:       fn = FN_SLT;
        default: fn = 6'($urandom_range(63));
      endcase
      return enc_r(rs, rt, 5'($urandom_range(31)), fn, 5'($urandom_range(31)));
    end
    if (pick < 70) return enc_i(OPC_LW, rs, rt, 16'($urandom));
    if (pick < 85) return enc_i(OPC_SW, rs, rt, 16'($urandom));
    // Half of the branches compare a register with itself, so they are taken.
    if (pick < 93) return enc_i(OPC_BEQ, rs, $urandom_range(1) ? rs : rt, 16'($urandom));
    if (pick < 97) return {OPC_J, 26'($urandom)};
    return $urandom;
  endfunction

  // Offers one word. It may idle for a few cycles first. It waits for the handshake and then
  // records the expected result. Valid is left high, so that a following word goes out
  // back to back.
  task automatic send_word(logic [1:0] op, logic [31:0] instr, logic [4:0] pidx,
                           logic [31:0] pval);
    retire_t exp_w;
    while (!quiet && $urandom_range(99) < 10) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.op            <= op;
    in_bus.instr         <= instr;
    in_bus.preload_index <= pidx;
    in_bus.preload_value <= pval;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    exp_w    = retire_word(op, instr, pidx, pval);
    retire_q = {retire_q, exp_w};
  endtask

  task automatic send_random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 84) send_word(OP_EXEC, random_instr(), 5'($urandom), $urandom);
    else if (pick < 94) send_word(OP_LOAD_REG, $urandom, 5'($urandom), $urandom);
    else if (pick < 99) send_word(OP_LOAD_MEM, $urandom, 5'($urandom), $urandom);
    else send_word(OP_UNUSED, $urandom, 5'($urandom), $urandom);
  endtask

  // Withdraws the input and holds it off until every outstanding result word has arrived.
  task automatic wait_results();
    in_bus.valid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
  endtask

  // Corner cases: arithmetic wrap, signed compare, writes aimed at register zero,
  // unsupported encodings, address wrap in the data memory, both branch outcomes, the
  // furthest jump and the unused op code.
  task automatic test_directed();
    send_word(OP_LOAD_REG, '0, 5'd1, 32'h7FFF_FFFF);
    send_word(OP_LOAD_REG, '0, 5'd2, 32'h8000_0000);
    send_word(OP_LOAD_REG, '0, 5'd3, 32'hFFFF_FFFF);
    send_word(OP_LOAD_REG, '0, 5'd0, 32'h1234_5678);
    send_word(OP_LOAD_MEM, '0, 5'd31, 32'hDEAD_BEEF);
    send_word(OP_LOAD_MEM, '0, 5'd0, 32'h0000_0001);
    send_word(OP_EXEC, enc_r(5'd1, 5'd1, 5'd4, FN_ADD), '0, '0);
    send_word(OP_EXEC, enc_r(5'd2, 5'd1, 5'd5, FN_SUB), '0, '0);
    send_word(OP_EXEC, enc_r(5'd1, 5'd3, 5'd6, FN_AND), '0, '0);
    send_word(OP_EXEC, enc_r(5'd2, 5'd1, 5'd7, FN_OR), '0, '0);
    send_word(OP_EXEC, enc_r(5'd0, 5'd0, 5'd8, FN_NOR), '0, '0);
    send_word(OP_EXEC, enc_r(5'd2, 5'd1, 5'd9, FN_SLT), '0, '0);
    send_word(OP_EXEC, enc_r(5'd1, 5'd2, 5'd10, FN_SLT), '0, '0);
    send_word(OP_EXEC, enc_r(5'd1, 5'd3, 5'd0, FN_ADD), '0, '0);
    send_word(OP_EXEC, enc_r(5'd1, 5'd3, 5'd11, 6'h21), '0, '0);
    send_word(OP_EXEC, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_word(OP_EXEC, enc_i(OPC_LW, 5'd0, 5'd12, 16'hFFFC), '0, '0);
    send_word(OP_EXEC, enc_i(OPC_LW, 5'd0, 5'd0, 16'h0000), '0, '0);
    send_word(OP_EXEC, enc_i(OPC_SW, 5'd0, 5'd3, 16'h0007), '0, '0);
    send_word(OP_EXEC, enc_i(OPC_SW, 5'd2, 5'd1, 16'h7FFC), '0, '0);
    send_word(OP_EXEC, enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hFFF8), '0, '0);
    send_word(OP_EXEC, enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h0005), '0, '0);
    send_word(OP_EXEC, {OPC_J, 26'h3FF_FFFF}, '0, '0);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
  endtask

  // Random programs, with idle cycles on both sides.
  task automatic test_random_program();
    repeat (650) send_random_word();
  endtask

  // A long stretch at full rate with neither side idling.
  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (300) send_random_word();
    quiet = 1'b0;
  endtask

  // The sender stops halfway and waits until the core has drained before it carries on.
  task automatic test_pause_mid_stream();
    repeat (200) send_random_word();
    wait_results();
    repeat (200) send_random_word();
  endtask

  // Raw words with every op code and arbitrary instruction bits.
  task automatic test_noise();
    repeat (80) send_word(2'($urandom_range(3)), $urandom, 5'($urandom), $urandom);
  endtask

  // The receiver stalls in about one cycle in ten, except while the full-rate stretch runs.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Each result word that is accepted is checked against the oldest outstanding expectation.
  // Signals are read at the clock edge, before any update made at that edge takes effect.
  always @(posedge clk_i) begin : result_check
    retire_t exp_r;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (retire_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with nothing outstanding: pc %h kind %0d idx %0d val %h",
                   $realtime, out_bus.next_pc, out_bus.write_kind, out_bus.write_index,
                   out_bus.write_value);
      end else begin
        exp_r = retire_q.pop_front();
        if (out_bus.next_pc !== exp_r.next_pc || out_bus.write_kind !== exp_r.kind ||
            out_bus.write_index !== exp_r.index || out_bus.write_value !== exp_r.value ||
            out_bus.executed_count !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected pc %h kind %0d idx %0d val %h count %0d",
                     $realtime, exp_r.next_pc, exp_r.kind, exp_r.index, exp_r.value,
                     exp_r.count);
            $display("%0t:           actual   pc %h kind %0d idx %0d val %h count %0d",
                     $realtime, out_bus.next_pc, out_bus.write_kind, out_bus.write_index,
                     out_bus.write_value, out_bus.executed_count);
          end
        end
      end
    end
  end

  initial begin
    in_bus.valid         <= 1'b0;
    in_bus.op            <= OP_EXEC;
    in_bus.instr         <= '0;
    in_bus.preload_index <= '0;
    in_bus.preload_value <= '0;
    rst_ni               <= 1'b0;
    mismatch_count = 0;
    quiet          = 1'b0;
    arch_pc        = '0;
    arch_count     = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // After reset the core clears its data memory before it takes words. The first
    // handshake simply waits for that to finish.
    test_directed();
    test_random_program();
    test_full_rate();
    test_pause_mid_stream();
    test_noise();
    wait_results();
    // A few more cycles, so that any surplus result word is caught as well.
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Upper bound on the run. It is many times what the slowest correct run needs.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/msc_pkg.sv
rtl/msc_if.sv
rtl/msc_regfile.sv
rtl/msc_word_slot.sv
rtl/mips_subset_single_cycle_core_top.sv
rtl/msc_checker.sv
verif/mips_subset_single_cycle_core_top_test.sv
